FILE: hdl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fitb_pkg.sv
`timescale 1ns / 1ps

package fitb_pkg;

  localparam int COUNT_BITS = 24;

  localparam int TICK_BITS    = 8;
  localparam int PERIOD_BITS  = 16;
  localparam int TICKNS_BITS  = 8;
  localparam int FIELD_BITS   = 24;
  localparam int ELAPSED_BITS = 24;
  // Dividend and quotient carry one bit above the elapsed time.
  localparam int QUOT_BITS    = ELAPSED_BITS + 1;
  localparam int SUM_BITS     = ((COUNT_BITS > QUOT_BITS) ? COUNT_BITS : QUOT_BITS) + 1;
  localparam int COMP_BITS    = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

  localparam int MUL_STEPS = TICK_BITS;
  localparam int DIV_STEPS = QUOT_BITS;
  localparam int MUL_CNT_BITS = $clog2(MUL_STEPS);
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 24;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CLOCK_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TICK_NS      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_LIMIT   = 2'd2;

  localparam logic [PERIOD_BITS-1:0] CLOCK_PERIOD_RESET = 16'd2000;
  localparam logic [TICKNS_BITS-1:0] TICK_NS_RESET      = 8'd83;
  localparam logic [FIELD_BITS-1:0]  CELL_LIMIT_RESET   = 24'hFFFFFF;

  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};
  localparam logic [FIELD_BITS-1:0]   FIELD_MAX   = {FIELD_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]   COUNT_MAX   = {COUNT_BITS{1'b1}};

endpackage

FILE: hdl/flux_interval_to_bitcell_decoder.sv
`timescale 1ns / 1ps
// A request that yields a cell passes a bit-serial multiply, a compare, a restoring divide
// and an update, which waits for a free output register before it registers the result.
// A merged interval returns to idle after the multiply and compare; a request on a stopped
// track is dropped in idle. New requests are taken only in idle, after the previous one ends.
// Reset (rst, synchronous): registers return to defaults, time, cell count and stop clear;
// no memory, so no clearing pass.
module flux_interval_to_bitcell_decoder (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [fitb_pkg::TICK_BITS-1:0]        interval_ticks,
  input  logic                                  new_track,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [fitb_pkg::FIELD_BITS-1:0]       cell_index,
  output logic [fitb_pkg::FIELD_BITS-1:0]       gap_cells,
  output logic                                  overrun,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fitb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [fitb_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0] state;

  logic [fitb_pkg::PERIOD_BITS-1:0]  cell_period;
  logic [fitb_pkg::TICKNS_BITS-1:0]  tick_ns;
  logic [fitb_pkg::FIELD_BITS-1:0]   cell_limit;

  logic [fitb_pkg::ELAPSED_BITS-1:0] elapsed;
  logic [fitb_pkg::COUNT_BITS-1:0]   cell_count;
  logic                              stopped;

  logic [fitb_pkg::QUOT_BITS-1:0]    acc;
  logic [fitb_pkg::TICK_BITS-1:0]    mplier;
  logic [fitb_pkg::PERIOD_BITS-1:0]  mcand;
  logic [fitb_pkg::MUL_CNT_BITS-1:0] mul_cnt;
  logic [fitb_pkg::QUOT_BITS-1:0]    dq;
  logic [fitb_pkg::PERIOD_BITS-1:0]  rem;
  logic [fitb_pkg::DIV_CNT_BITS-1:0] div_cnt;

  logic [fitb_pkg::PERIOD_BITS-1:0]  period_eff;
  logic [fitb_pkg::PERIOD_BITS+1:0]  thr_wide;
  logic [fitb_pkg::PERIOD_BITS-1:0]  threshold;
  logic [fitb_pkg::ELAPSED_BITS-1:0] elapsed_sat;
  logic                              merge;
  logic [fitb_pkg::QUOT_BITS-1:0]    dividend;
  logic [fitb_pkg::PERIOD_BITS:0]    rem_shift;
  logic                              rem_ge;
  logic [fitb_pkg::PERIOD_BITS-1:0]  rem_next;
  logic [fitb_pkg::SUM_BITS-1:0]     sum;
  logic [fitb_pkg::COUNT_BITS-1:0]   count_next;
  logic                              hit;
  logic                              out_free;
  logic                              in_take;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    period_eff  = (cell_period == '0) ? fitb_pkg::PERIOD_BITS'(1) : cell_period;
    // 3 * period / 4, truncated
    thr_wide    = {2'b00, period_eff} + {1'b0, period_eff, 1'b0};
    threshold   = thr_wide[fitb_pkg::PERIOD_BITS+1:2];
    elapsed_sat = acc[fitb_pkg::QUOT_BITS-1] ? fitb_pkg::ELAPSED_MAX
                                             : acc[fitb_pkg::ELAPSED_BITS-1:0];
    merge       = elapsed_sat < fitb_pkg::ELAPSED_BITS'(threshold);
    dividend    = {1'b0, elapsed_sat}
                + fitb_pkg::QUOT_BITS'(period_eff[fitb_pkg::PERIOD_BITS-1:1]);
    rem_shift   = {rem, dq[fitb_pkg::QUOT_BITS-1]};
    rem_ge      = rem_shift >= {1'b0, period_eff};
    rem_next    = rem_ge ? fitb_pkg::PERIOD_BITS'(rem_shift - {1'b0, period_eff})
                         : rem_shift[fitb_pkg::PERIOD_BITS-1:0];
    sum         = fitb_pkg::SUM_BITS'(cell_count) + fitb_pkg::SUM_BITS'(dq);
    count_next  = (sum > fitb_pkg::SUM_BITS'(fitb_pkg::COUNT_MAX)) ? fitb_pkg::COUNT_MAX
                : sum[fitb_pkg::COUNT_BITS-1:0];
    hit         = fitb_pkg::COMP_BITS'(count_next) >= fitb_pkg::COMP_BITS'(cell_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cell_period  <= fitb_pkg::CLOCK_PERIOD_RESET;
      tick_ns      <= fitb_pkg::TICK_NS_RESET;
      cell_limit   <= fitb_pkg::CELL_LIMIT_RESET;
      elapsed      <= '0;
      cell_count   <= '0;
      stopped      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          fitb_pkg::REG_CLOCK_PERIOD: cell_period  <= cfg_data[fitb_pkg::PERIOD_BITS-1:0];
          fitb_pkg::REG_TICK_NS:      tick_ns      <= cfg_data[fitb_pkg::TICKNS_BITS-1:0];
          fitb_pkg::REG_CELL_LIMIT:   cell_limit   <= cfg_data[fitb_pkg::FIELD_BITS-1:0];
          default: ;
        endcase
      end

      if (out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (new_track) begin
              elapsed    <= '0;
              cell_count <= '0;
              stopped    <= 1'b0;
            end
            // drop the request when the track is stopped and no new track starts
            if (new_track || !stopped) begin
              acc     <= new_track ? '0 : {1'b0, elapsed};
              mplier  <= interval_ticks;
              mcand   <= fitb_pkg::PERIOD_BITS'(tick_ns);
              mul_cnt <= '0;
              state   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mplier[0]) begin
            acc <= acc + fitb_pkg::QUOT_BITS'(mcand);
          end
          mcand  <= {mcand[fitb_pkg::PERIOD_BITS-2:0], 1'b0};
          mplier <= {1'b0, mplier[fitb_pkg::TICK_BITS-1:1]};
          if (mul_cnt == fitb_pkg::MUL_CNT_BITS'(fitb_pkg::MUL_STEPS - 1)) begin
            state <= S_CHK;
          end else begin
            mul_cnt <= mul_cnt + 1'b1;
          end
        end
        S_CHK: begin
          if (merge) begin
            elapsed <= elapsed_sat;
            state   <= S_IDLE;
          end else begin
            dq      <= dividend;
            rem     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_next;
          dq  <= {dq[fitb_pkg::QUOT_BITS-2:0], rem_ge};
          if (div_cnt == fitb_pkg::DIV_CNT_BITS'(fitb_pkg::DIV_STEPS - 1)) begin
            state <= S_FIN;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            cell_count <= count_next;
            elapsed    <= '0;
            stopped    <= hit;
            out_valid  <= 1'b1;
            cell_index <= hit ? '0 : fitb_pkg::FIELD_BITS'(count_next);
            gap_cells  <= dq[fitb_pkg::QUOT_BITS-1] ? fitb_pkg::FIELD_MAX
                                                    : dq[fitb_pkg::FIELD_BITS-1:0];
            overrun    <= hit;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_rem_below_period, (state != S_DIV) || (rem < period_eff), "remainder not below period")
  `ASSERT_ALWAYS(a_stop_clears_time, !stopped || (elapsed == '0), "stopped track holds time")
  `ASSERT_ALWAYS(a_overrun_index, !(out_valid && overrun) || (cell_index == '0), "overrun with index")
  `ASSERT_NEXT(a_stopped_drop, in_take && stopped && !new_track, state == S_IDLE, "stopped request not dropped")

endmodule

FILE: tb/cell_mark_checker.sv
`timescale 1ns / 1ps

module cell_mark_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [fitb_pkg::TICK_BITS-1:0]      interval_ticks,
  input  logic                                new_track,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [fitb_pkg::FIELD_BITS-1:0]     cell_index,
  input  logic [fitb_pkg::FIELD_BITS-1:0]     gap_cells,
  input  logic                                overrun,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [fitb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fitb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  pending_marks,
  output int                                  mismatches
);

  typedef struct packed {
    logic [fitb_pkg::FIELD_BITS-1:0] cell_index;
    logic [fitb_pkg::FIELD_BITS-1:0] gap_cells;
    logic                            overrun;
  } cell_mark_t;

  cell_mark_t expected_marks[$];

  logic [fitb_pkg::PERIOD_BITS-1:0]  period_ns;
  logic [fitb_pkg::TICKNS_BITS-1:0]  tick_len_ns;
  logic [fitb_pkg::FIELD_BITS-1:0]   limit_cells;
  logic [fitb_pkg::ELAPSED_BITS-1:0] track_ns;
  logic [fitb_pkg::COUNT_BITS-1:0]   cells_so_far;
  logic                              track_halted;

  int fail_count = 0;

  assign mismatches = fail_count;

  task automatic report_mismatch(input string what, input logic [fitb_pkg::FIELD_BITS-1:0] got,
                                 input logic [fitb_pkg::FIELD_BITS-1:0] want);
    fail_count++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  task automatic apply_register(input logic [fitb_pkg::CFG_INDEX_BITS-1:0] idx,
                                input logic [fitb_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      fitb_pkg::REG_CLOCK_PERIOD: begin
        period_ns = data[fitb_pkg::PERIOD_BITS-1:0];
      end
      fitb_pkg::REG_TICK_NS: begin
        tick_len_ns = data[fitb_pkg::TICKNS_BITS-1:0];
      end
      fitb_pkg::REG_CELL_LIMIT: begin
        limit_cells = data[fitb_pkg::FIELD_BITS-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic predict_cell_mark(input logic [fitb_pkg::TICK_BITS-1:0] ticks,
                                   input logic fresh);
    longint unsigned sum_ns;
    longint unsigned per;
    longint unsigned thr;
    longint unsigned cells;
    longint unsigned total;
    cell_mark_t      mark;
    if (fresh) begin
      track_ns = '0;
      cells_so_far = '0;
      track_halted = 1'b0;
    end
    if (track_halted) return;
    sum_ns = track_ns + ticks * tick_len_ns;
    track_ns = (sum_ns > fitb_pkg::ELAPSED_MAX) ? fitb_pkg::ELAPSED_MAX
                                                : sum_ns[fitb_pkg::ELAPSED_BITS-1:0];
    per = (period_ns == 0) ? 1 : period_ns;
    thr = (3 * per) >> 2;
    // merge into the next interval while under three quarters of a cell
    if (track_ns < thr) return;
    cells = (track_ns + (per >> 1)) / per;
    total = cells_so_far + cells;
    cells_so_far = (total > fitb_pkg::COUNT_MAX) ? fitb_pkg::COUNT_MAX
                                                 : total[fitb_pkg::COUNT_BITS-1:0];
    track_ns = '0;
    mark.gap_cells = (cells > fitb_pkg::FIELD_MAX) ? fitb_pkg::FIELD_MAX
                                                   : cells[fitb_pkg::FIELD_BITS-1:0];
    if (cells_so_far >= limit_cells) begin
      track_halted = 1'b1;
      mark.cell_index = '0;
      mark.overrun = 1'b1;
    end else begin
      mark.cell_index = cells_so_far[fitb_pkg::FIELD_BITS-1:0];
      mark.overrun = 1'b0;
    end
    expected_marks.push_back(mark);
  endtask

  task automatic check_cell_mark();
    cell_mark_t want;
    if (expected_marks.size() == 0) begin
      report_mismatch("result with nothing expected, cell_index", cell_index, '0);
      return;
    end
    want = expected_marks.pop_front();
    if (cell_index !== want.cell_index) report_mismatch("cell_index", cell_index, want.cell_index);
    if (gap_cells !== want.gap_cells) report_mismatch("gap_cells", gap_cells, want.gap_cells);
    if (overrun !== want.overrun) report_mismatch("overrun", overrun, want.overrun);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      period_ns = fitb_pkg::CLOCK_PERIOD_RESET;
      tick_len_ns = fitb_pkg::TICK_NS_RESET;
      limit_cells = fitb_pkg::CELL_LIMIT_RESET;
      track_ns = '0;
      cells_so_far = '0;
      track_halted = 1'b0;
      expected_marks.delete();
      pending_marks <= 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
      // compare first: a result leaving now always belongs to an older request
      if (out_valid && out_ready) check_cell_mark();
      if (in_valid && in_ready) predict_cell_mark(interval_ticks, new_track);
      pending_marks <= expected_marks.size();
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [fitb_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int RANDOM_PHASES   = 5;
  localparam int PHASE_REQUESTS  = 160;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [fitb_pkg::TICK_BITS-1:0]      interval_ticks = '0;
  logic                                new_track = 1'b0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [fitb_pkg::FIELD_BITS-1:0]     cell_index;
  logic [fitb_pkg::FIELD_BITS-1:0]     gap_cells;
  logic                                overrun;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [fitb_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [fitb_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

  int pending_marks;
  int mismatches;
  int quiet_cycles = 0;

  bit steady = 1'b0;
  bit hold_request = 1'b0;
  int unsigned cur_period = 32'(fitb_pkg::CLOCK_PERIOD_RESET);
  int unsigned cur_tick = 32'(fitb_pkg::TICK_NS_RESET);

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  flux_interval_to_bitcell_decoder DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .interval_ticks(interval_ticks), .new_track(new_track),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_index(cell_index), .gap_cells(gap_cells), .overrun(overrun),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cell_mark_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .interval_ticks(interval_ticks), .new_track(new_track),
    .out_valid(out_valid), .out_ready(out_ready),
    .cell_index(cell_index), .gap_cells(gap_cells), .overrun(overrun),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending_marks(pending_marks), .mismatches(mismatches)
  );

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_interval(input logic [fitb_pkg::TICK_BITS-1:0] ticks, input logic fresh);
    if (!steady && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    interval_ticks <= ticks;
    new_track <= fresh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, wait out every expected result, then let a merged request finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_marks != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fitb_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [fitb_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      fitb_pkg::REG_CLOCK_PERIOD: cur_period = 32'(data[fitb_pkg::PERIOD_BITS-1:0]);
      fitb_pkg::REG_TICK_NS:      cur_tick = 32'(data[fitb_pkg::TICKNS_BITS-1:0]);
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  // ticks that land near a whole number of cells, with some jitter
  function automatic int unsigned aimed_ticks();
    int unsigned per;
    int unsigned step;
    int unsigned target;
    per = (cur_period == 0) ? 1 : cur_period;
    step = (cur_tick == 0) ? 1 : cur_tick;
    target = $urandom_range(1, 4) * per + $urandom_range(0, per / 2);
    target = (target > per / 4) ? target - per / 4 : 0;
    target = target / step;
    return (target > 255) ? 255 : target;
  endfunction

  initial begin
    int unsigned tick_val;
    int unsigned period_val;
    int unsigned track_left;
    int unsigned ticks;
    bit          fresh;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // default registers: merging, zero interval, new track mid-run
    send_interval(0, 1);
    send_interval(24, 0);
    send_interval(10, 0);
    send_interval(10, 0);
    send_interval(255, 0);
    send_interval(17, 0);
    send_interval(0, 0);
    send_interval(1, 0);
    send_interval(1, 0);
    send_interval(48, 0);
    send_interval(36, 1);
    send_interval(42, 0);
    settle();

    // zero period and zero limit: first result overruns, stopped track ignores
    write_reg(fitb_pkg::REG_CLOCK_PERIOD, 0);
    write_reg(fitb_pkg::REG_TICK_NS, 1);
    write_reg(fitb_pkg::REG_CELL_LIMIT, 0);
    send_interval(0, 1);
    send_interval(5, 0);
    send_interval(255, 0);
    send_interval(3, 1);
    settle();

    // zero tick length, spare index must change nothing
    write_reg(fitb_pkg::REG_TICK_NS, 0);
    write_reg(fitb_pkg::REG_CELL_LIMIT, 5);
    write_reg(REG_SPARE, fitb_pkg::FIELD_MAX);
    send_interval(255, 1);
    settle();
    write_reg(fitb_pkg::REG_TICK_NS, 1);
    send_interval(2, 0);
    send_interval(3, 0);
    send_interval(4, 0);
    settle();

    // largest period and tick
    write_reg(fitb_pkg::REG_CLOCK_PERIOD, 24'hFFFFFF);
    write_reg(fitb_pkg::REG_TICK_NS, 255);
    write_reg(fitb_pkg::REG_CELL_LIMIT, fitb_pkg::FIELD_MAX);
    send_interval(255, 1);
    send_interval(192, 0);
    send_interval(1, 0);
    send_interval(128, 0);
    send_interval(128, 0);
    settle();

    // drive the cell count into saturation, no idling on either side
    write_reg(fitb_pkg::REG_CLOCK_PERIOD, 1);
    steady = 1'b1;
    send_interval(255, 1);
    repeat (259) send_interval(255, 0);
    steady = 1'b0;
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      tick_val = $urandom_range(4, 255);
      if (p == RANDOM_PHASES - 1)
        period_val = $urandom_range(1, tick_val);
      else
        period_val = tick_val * $urandom_range(2, 60) + $urandom_range(0, tick_val - 1);
      write_reg(fitb_pkg::REG_CLOCK_PERIOD, {8'($urandom_range(0, 255)), 16'(period_val)});
      write_reg(fitb_pkg::REG_TICK_NS, {16'($urandom_range(0, 65535)), 8'(tick_val)});
      write_reg(fitb_pkg::REG_CELL_LIMIT,
                fitb_pkg::CFG_DATA_BITS'($urandom_range(20, 400)));
      if (p == 0) hold_request = 1'b1;
      track_left = 0;
      for (int i = 0; i < PHASE_REQUESTS; i++) begin
        fresh = (track_left == 0);
        if (fresh) track_left = $urandom_range(8, 60);
        track_left--;
        if ($urandom_range(0, 99) < 15) begin
          ticks = $urandom_range(0, 255);
          fresh = fresh | ($urandom_range(0, 7) == 0);
        end else begin
          ticks = aimed_ticks();
        end
        send_interval(fitb_pkg::TICK_BITS'(ticks), fresh);
      end
      settle();
    end

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: flux_interval_to_bitcell_decoder.f
+incdir+hdl
hdl/fitb_pkg.sv
hdl/flux_interval_to_bitcell_decoder.sv
tb/cell_mark_checker.sv
tb/tb.sv
